/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Wrappers around concurrent assertions. A synthesis build defines SYNTH,
// and then every use expands to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked only outside reset.
`define PIDT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, including during reset.
`define PIDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PIDT_ASSERT(lbl, clk, rst, prop, msg)
`define PIDT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* rtl/core/pidt_pkg.sv */
// ----------------------------------------------------------------------------
// pidt_pkg
// Types, sizes and helpers shared by the process id allocator table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pidt_pkg;

  localparam int SLOTS    = 256;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LAST_ID  = 32767;
  localparam int FIRST_ID = 1;

  localparam int ID_W  = 15;
  localparam int IDX_W = 8;

  // One full turn of the rotating counter.
  localparam int ALLOC_TRIES = LAST_ID - FIRST_ID;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_FIND  = 2'd2;

  typedef struct packed {
    logic            active;
    logic [ID_W-1:0] grp;
    logic [ID_W-1:0] id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  function automatic logic [ID_W-1:0] advance_id(input logic [ID_W-1:0] cur);
    logic [ID_W-1:0] nxt;
    if (cur < ID_W'(LAST_ID)) begin
      nxt = cur + 1'b1;
    end else begin
      nxt = ID_W'(FIRST_ID + 1);
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/pidt_ram.sv */
// ----------------------------------------------------------------------------
// pidt_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pidt_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 31,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/process_id_allocator_table.sv */
// ----------------------------------------------------------------------------
// process_id_allocator_table
// Slot table of process id, group id and in-use mark, with slot write,
// free id allocation from a rotating counter, and find by id.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake          | Beat contents
//   --------+--------------------+----------------------------------------------
//   input   | in_valid, in_stall | mode, slot_index, slot_id, slot_group_id,
//           |                    | slot_active, lookup_id
//   output  | out_valid,out_stall| new_id, found, found_slot
//
// A write, or an unused mode, goes from ST_IDLE to ST_RESULT and loads the
// output register from there; the next input beat can be taken after that load.
// A find reads the table through the single RAM read port, one slot a cycle,
// and stops at the first match. An allocate scans the table once per candidate
// id, over at most LAST_ID - FIRST_ID ids.
// After reset a clearing pass zeroes the table slot by slot, with in_stall
// high throughout. A result held by out_stall does not block the next input
// beat; only the following result waits for the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module process_id_allocator_table (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                mode,
  input  wire logic [pidt_pkg::IDX_W-1:0] slot_index,
  input  wire logic [pidt_pkg::ID_W-1:0] slot_id,
  input  wire logic [pidt_pkg::ID_W-1:0] slot_group_id,
  input  wire logic                      slot_active,
  input  wire logic [pidt_pkg::ID_W-1:0] lookup_id,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic      [pidt_pkg::ID_W-1:0] new_id,
  output logic                           found,
  output logic      [pidt_pkg::IDX_W-1:0] found_slot
);

  import pidt_pkg::*;

  state_t state, state_next;

  logic [SLOT_W-1:0] ra;
  logic              issue_done;
  logic              rd_vld;
  logic [SLOT_W-1:0] rd_idx;
  entry_t            rd_data;

  logic              op_find;
  logic [ID_W-1:0]   look;
  logic [ID_W-1:0]   last_id;
  logic [ID_W-1:0]   tries;

  logic [ID_W-1:0]   res_new_id, res_new_id_next;
  logic              res_found, res_found_next;
  logic [IDX_W-1:0]  res_slot, res_slot_next;
  logic              res_set;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  entry_t            ram_wdata;

  logic              accept;
  logic              start_scan;
  logic              retry;
  logic              hit;
  logic              idx_ok;
  logic              out_free;
  logic              out_load;

  pidt_ram #(
    .DEPTH (SLOTS),
    .WIDTH (ENTRY_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ra),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    idx_ok   = (32'(slot_index) < SLOTS);
    out_free = !out_valid || !out_stall;
    hit      = op_find ? (rd_data.active && (rd_data.id == look))
                       : ((rd_data.id == last_id) || (rd_data.grp == last_id));

    state_next      = state;
    in_stall        = 1'b1;
    accept          = 1'b0;
    start_scan      = 1'b0;
    retry           = 1'b0;
    res_set         = 1'b0;
    res_new_id_next = '0;
    res_found_next  = 1'b0;
    res_slot_next   = '0;
    ram_we          = 1'b0;
    ram_waddr       = ra;
    ram_wdata       = '0;
    out_load        = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (ra == LAST_SLOT) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (in_valid) begin
          if ((mode == MODE_ALLOC) || (mode == MODE_FIND)) begin
            start_scan = 1'b1;
            state_next = ST_SCAN;
          end else begin
            // Writes and the unused mode give an all-zero result.
            res_set    = 1'b1;
            state_next = ST_RESULT;
            if ((mode == MODE_WRITE) && idx_ok) begin
              ram_we    = 1'b1;
              ram_waddr = SLOT_W'(slot_index);
              ram_wdata = '{active: slot_active, grp: slot_group_id, id: slot_id};
            end
          end
        end
      end
      ST_SCAN: begin
        if (rd_vld) begin
          if (hit) begin
            if (op_find) begin
              res_set        = 1'b1;
              res_found_next = 1'b1;
              res_slot_next  = IDX_W'(rd_idx);
              state_next     = ST_RESULT;
            end else if (tries == ID_W'(ALLOC_TRIES)) begin
              // Every candidate of a full turn is taken.
              res_set    = 1'b1;
              state_next = ST_RESULT;
            end else begin
              retry = 1'b1;
            end
          end else if (rd_idx == LAST_SLOT) begin
            res_set         = 1'b1;
            res_new_id_next = op_find ? '0 : last_id;
            state_next      = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Read sequencer: addresses go out one a cycle, and data comes back registered
  // by the RAM, tagged with rd_idx. A retry drops the read still in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      ra         <= '0;
      issue_done <= 1'b0;
      rd_vld     <= 1'b0;
    end else if (state == ST_CLEAR) begin
      ra         <= (ra == LAST_SLOT) ? '0 : ra + 1'b1;
      issue_done <= 1'b0;
      rd_vld     <= 1'b0;
    end else if (start_scan || retry || (state != ST_SCAN)) begin
      ra         <= '0;
      issue_done <= 1'b0;
      rd_vld     <= 1'b0;
    end else begin
      rd_vld <= !issue_done;
      if (!issue_done) begin
        if (ra == LAST_SLOT) begin
          issue_done <= 1'b1;
        end else begin
          ra <= ra + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= ra;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_id <= ID_W'(FIRST_ID + 1);
      tries   <= '0;
    end else if (start_scan && (mode == MODE_ALLOC)) begin
      last_id <= advance_id(last_id);
      tries   <= ID_W'(1);
    end else if (retry) begin
      last_id <= advance_id(last_id);
      tries   <= tries + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_find <= (mode == MODE_FIND);
      look    <= lookup_id;
    end
    if (res_set) begin
      res_new_id <= res_new_id_next;
      res_found  <= res_found_next;
      res_slot   <= res_slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      new_id     <= res_new_id;
      found      <= res_found;
      found_slot <= res_slot;
    end
  end

  `PIDT_ASSERT(a_found_no_id, clk, rst,
               (out_valid && found) |-> (new_id == '0),
               "find result carries an id")
  `PIDT_ASSERT(a_slot_needs_hit, clk, rst,
               (out_valid && !found) |-> (found_slot == '0),
               "slot index without a match")
  `PIDT_ASSERT(a_id_in_range, clk, rst,
               (out_valid && (new_id != '0)) |->
                 ((new_id > ID_W'(FIRST_ID)) && (new_id <= ID_W'(LAST_ID))),
               "allocated id out of range")
  `PIDT_ASSERT(a_tries_bound, clk, rst,
               tries <= ID_W'(ALLOC_TRIES),
               "allocate ran past a full turn")
  `PIDT_ASSERT(a_load_from_result, clk, rst,
               $rose(out_valid) |-> ($past(state) == ST_RESULT),
               "result beat without a finished operation")

endmodule

`default_nettype wire
